[rtl/pipm_pkg.sv]
// Types and constants shared by the pulse interval power meter modules.
package pipm_pkg;

    localparam int TIMER_FIELD_W = 16;
    localparam int ADC_FIELD_W   = 10;
    localparam int OUT_W         = 16;
    localparam int TICK_W        = 16;
    localparam int ENERGY_W      = 26;
    localparam int REPORT_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int ELAPSED_W     = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 26;

    // Serial multiplier operand width and serial divider widths
    localparam int MUL_W = 16;
    localparam int DIV_W = 32;
    localparam int DVS_W = 23;

    localparam logic [DVS_W-1:0] US_PER_MS = DVS_W'(1000);
    localparam logic [OUT_W-1:0] SAT16     = 16'hFFFF;

    localparam logic [TICK_W-1:0]   TICK_RESET   = 16'd1024;
    localparam logic [ENERGY_W-1:0] ENERGY_RESET = 26'd3600000;
    localparam logic [REPORT_W-1:0] REPORT_RESET = 16'd1000;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd10956;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd3;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [TIMER_FIELD_W-1:0] timer_count;
        logic [ADC_FIELD_W-1:0]   adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] pulse_count;
        logic [OUT_W-1:0] power_w;
        logic [OUT_W-1:0] voltage_mv;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] multiplicand;
        logic [MUL_W-1:0] multiplier;
    } mul_req_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

[rtl/pipm_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pipm_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pipm_pkg::mul_req_t          req,
    output logic                        done,
    output logic [2*pipm_pkg::MUL_W-1:0] product
);

    localparam int W   = pipm_pkg::MUL_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     hi_reg;
    logic [W-1:0]     lo_reg;
    logic             done_reg;
    logic [W:0]       sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.multiplicand;
            hi_reg <= '0;
            lo_reg <= req.multiplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[W:1];
            lo_reg <= {sum[0], lo_reg[W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

[rtl/pipm_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module pipm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pipm_pkg::div_req_t          req,
    output logic                        done,
    output logic [pipm_pkg::DIV_W-1:0]  quotient
);

    localparam int W     = pipm_pkg::DIV_W;
    localparam int DW    = pipm_pkg::DVS_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    dvs_reg;
    logic [DW-1:0]    rem_reg;
    logic [W-1:0]     dvd_reg;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_diff;
    logic             q_bit;

    // Bring down the next dividend bit and try to subtract
    assign rem_sh   = {rem_reg, dvd_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign q_bit    = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift into the dividend register from the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg <= req.divisor;
            dvd_reg <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            dvd_reg <= {dvd_reg[W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[rtl/pulse_interval_power_meter_top.sv]
// Top level of the pulse interval power meter.
//
// Input channel (in_valid, in_stall, in_data) takes one transaction per item:
// a meter pulse carries the timer counts since the previous pulse, a poll
// carries an ADC sample. Output channel (out_valid, out_stall, out_data)
// delivers a report transaction only on a poll that finds a new pulse count
// and enough accumulated time. Configuration writes arrive on cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// One item is worked at a time. A pulse runs a serial multiply of counts
// by tick period, a serial divide by 1000 and a serial divide of energy by
// the interval; the last divide is skipped when the interval is 0 ms.
// A reporting poll runs the serial voltage multiply and then the output
// load; a poll that does not report ends as it is accepted. The 16-bit shift
// multiplier and the 32-step restoring divider do this arithmetic.
// The output register holds a finished report while the next items are
// accepted; a report waits in its last step only while an earlier report is
// still stalled by the receiver. Reset clears pulse count, running time and
// power, loads the default configuration and empties the output register.
module pulse_interval_power_meter_top #(
    parameter int TIMER_BITS = 16,
    parameter int ADC_BITS   = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  pipm_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pipm_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pipm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pipm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int TF_W = pipm_pkg::TIMER_FIELD_W;
    localparam int AF_W = pipm_pkg::ADC_FIELD_W;
    localparam int CNT_BITS = (TIMER_BITS < TF_W) ? TIMER_BITS : TF_W;
    localparam int ADC_USED = (ADC_BITS < AF_W) ? ADC_BITS : AF_W;
    localparam logic [TF_W-1:0] CNT_MASK = TF_W'((33'd1 << CNT_BITS) - 33'd1);
    localparam logic [AF_W-1:0] ADC_MASK = AF_W'((33'd1 << ADC_USED) - 33'd1);

    localparam int MW = pipm_pkg::MUL_W;
    localparam int DW = pipm_pkg::DIV_W;
    localparam int SW = pipm_pkg::DVS_W;
    localparam int OW = pipm_pkg::OUT_W;
    localparam int EW = pipm_pkg::ELAPSED_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DMS  = 3'd2;
    localparam logic [2:0] S_DPW  = 3'd3;
    localparam logic [2:0] S_VMUL = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [pipm_pkg::TICK_W-1:0]   tick_reg;
    logic [pipm_pkg::ENERGY_W-1:0] energy_reg;
    logic [pipm_pkg::REPORT_W-1:0] report_reg;
    logic [pipm_pkg::GAIN_W-1:0]   gain_reg;

    logic [OW-1:0] pulse_total_reg;
    logic [OW-1:0] last_reported_reg;
    logic [EW-1:0] elapsed_reg;
    logic [OW-1:0] last_power_reg;
    logic [OW-1:0] volt_reg;

    logic                out_valid_reg;
    pipm_pkg::out_item_t out_data_reg;

    pipm_pkg::mul_req_t  mul_req;
    pipm_pkg::div_req_t  div_req;
    logic                mul_done;
    logic                div_done;
    logic [2*MW-1:0]     product;
    logic [DW-1:0]       quotient;

    logic          in_accept;
    logic          poll_reports;
    logic          out_free;
    logic [SW-1:0] ms;
    logic [EW:0]   elapsed_sum;
    logic [OW-1:0] volt_sat;
    logic [OW-1:0] power_sat;

    pipm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (product)
    );

    pipm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign poll_reports = (pulse_total_reg != last_reported_reg) &&
                          (elapsed_reg >= {{(EW-pipm_pkg::REPORT_W){1'b0}}, report_reg});

    // Interval fits 23 bits: a 32-bit product divided by 1000
    assign ms          = quotient[SW-1:0];
    assign elapsed_sum = {1'b0, elapsed_reg} + (EW+1)'(ms);
    assign power_sat   = (quotient[DW-1:OW] != '0) ? pipm_pkg::SAT16 : quotient[OW-1:0];
    assign volt_sat    = (product[2*MW-1:OW+8] != '0) ? pipm_pkg::SAT16
                                                      : product[OW+7:8];

    always_comb
    begin
        state_next           = state_reg;
        mul_req.start        = 1'b0;
        mul_req.multiplicand = tick_reg;
        mul_req.multiplier   = in_data.timer_count & CNT_MASK;
        div_req.start        = 1'b0;
        div_req.dividend     = product;
        div_req.divisor      = pipm_pkg::US_PER_MS;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.operation == pipm_pkg::OP_PULSE)
                    begin
                        mul_req.start = 1'b1;
                        state_next    = S_MUL;
                    end
                    else if (poll_reports)
                    begin
                        mul_req.start        = 1'b1;
                        mul_req.multiplicand = gain_reg;
                        mul_req.multiplier   = MW'(in_data.adc_sample & ADC_MASK);
                        state_next           = S_VMUL;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DMS;
                end
            end
            S_DMS:
            begin
                if (div_done)
                begin
                    if (ms != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DW'(energy_reg);
                        div_req.divisor  = ms;
                        state_next       = S_DPW;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DPW:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_VMUL:
            begin
                if (mul_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            tick_reg          <= pipm_pkg::TICK_RESET;
            energy_reg        <= pipm_pkg::ENERGY_RESET;
            report_reg        <= pipm_pkg::REPORT_RESET;
            gain_reg          <= pipm_pkg::GAIN_RESET;
            pulse_total_reg   <= '0;
            last_reported_reg <= '0;
            elapsed_reg       <= '0;
            last_power_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pipm_pkg::CFG_TICK:   tick_reg   <= cfg_data[pipm_pkg::TICK_W-1:0];
                    pipm_pkg::CFG_ENERGY: energy_reg <= cfg_data[pipm_pkg::ENERGY_W-1:0];
                    pipm_pkg::CFG_REPORT: report_reg <= cfg_data[pipm_pkg::REPORT_W-1:0];
                    pipm_pkg::CFG_GAIN:   gain_reg   <= cfg_data[pipm_pkg::GAIN_W-1:0];
                    default:              tick_reg   <= tick_reg;
                endcase
            end

            // Add the interval to the running time, saturating
            if (state_reg == S_DMS && div_done)
            begin
                elapsed_reg <= elapsed_sum[EW] ? {EW{1'b1}} : elapsed_sum[EW-1:0];
                if (ms == '0)
                begin
                    last_power_reg  <= pipm_pkg::SAT16;
                    pulse_total_reg <= pulse_total_reg + 1'b1;
                end
            end

            if (state_reg == S_DPW && div_done)
            begin
                last_power_reg  <= power_sat;
                pulse_total_reg <= pulse_total_reg + 1'b1;
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg     <= 1'b1;
                last_reported_reg <= pulse_total_reg;
                elapsed_reg       <= '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_VMUL && mul_done)
        begin
            volt_reg <= volt_sat;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_data_reg.pulse_count <= pulse_total_reg;
            out_data_reg.power_w     <= last_power_reg;
            out_data_reg.voltage_mv  <= volt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A new report only ever comes out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EMIT))
        else $error("report appeared outside the emit step");

    a_pulse_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.operation == pipm_pkg::OP_PULSE) |=> (state_reg == S_MUL))
        else $error("pulse transaction did not start the multiplier");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL || state_reg == S_VMUL))
        else $error("multiplier finished with no step waiting for it");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DMS || state_reg == S_DPW))
        else $error("divider finished with no step waiting for it");

endmodule
